/* rtl/qrot_pkg.sv */
// shared types and constants of the quaternion vector rotation unit
package qrot_pkg;

  // quaternion components, signed Q2.14
  localparam int QUAT_W = 16;
  localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

  // rotation matrix terms, exact at 27 fraction bits
  localparam int MAT_W    = 33;
  localparam int MAT_FRAC = 27;
  localparam logic signed [MAT_W-1:0] MAT_ONE = 33'sd134217728;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 8'd3;

  typedef logic signed [MAT_W-1:0] mat_term_t;

  // one matrix row: weights of the x, y and z inputs
  typedef struct packed {
    mat_term_t m0;
    mat_term_t m1;
    mat_term_t m2;
  } mat_row_t;

  // per-stage load strobes of the datapath pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } qrot_adv_t;

endpackage

/* rtl/qrot_matrix.sv */
// quaternion registers and the rotation matrix derived from them
module qrot_matrix import qrot_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output mat_row_t              row_x,
  output mat_row_t              row_y,
  output mat_row_t              row_z
);

  localparam int PROD_W = 2*QUAT_W;

  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  logic signed [QUAT_W-1:0] quat_w;

  logic signed [PROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  mat_row_t row_x_next, row_y_next, row_z_next;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
      quat_w <= QUAT_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_QUAT_X: quat_x <= cfg_data;
        REG_QUAT_Y: quat_y <= cfg_data;
        REG_QUAT_Z: quat_z <= cfg_data;
        REG_QUAT_W: quat_w <= cfg_data;
        default: ;
      endcase
    end
  end

  // pairwise products, doubling folded into the matrix scale
  assign xx = PROD_W'(quat_x) * PROD_W'(quat_x);
  assign yy = PROD_W'(quat_y) * PROD_W'(quat_y);
  assign zz = PROD_W'(quat_z) * PROD_W'(quat_z);
  assign xy = PROD_W'(quat_x) * PROD_W'(quat_y);
  assign xz = PROD_W'(quat_x) * PROD_W'(quat_z);
  assign yz = PROD_W'(quat_y) * PROD_W'(quat_z);
  assign wx = PROD_W'(quat_w) * PROD_W'(quat_x);
  assign wy = PROD_W'(quat_w) * PROD_W'(quat_y);
  assign wz = PROD_W'(quat_w) * PROD_W'(quat_z);

  // matrix terms
  always_comb begin
    row_x_next.m0 = MAT_ONE - MAT_W'(yy) - MAT_W'(zz);
    row_x_next.m1 = MAT_W'(xy) - MAT_W'(wz);
    row_x_next.m2 = MAT_W'(xz) + MAT_W'(wy);
    row_y_next.m0 = MAT_W'(xy) + MAT_W'(wz);
    row_y_next.m1 = MAT_ONE - MAT_W'(xx) - MAT_W'(zz);
    row_y_next.m2 = MAT_W'(yz) - MAT_W'(wx);
    row_z_next.m0 = MAT_W'(xz) - MAT_W'(wy);
    row_z_next.m1 = MAT_W'(yz) + MAT_W'(wx);
    row_z_next.m2 = MAT_ONE - MAT_W'(xx) - MAT_W'(yy);
  end

  // matrix registers, identity out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x <= '{m0: MAT_ONE, m1: '0, m2: '0};
      row_y <= '{m0: '0, m1: MAT_ONE, m2: '0};
      row_z <= '{m0: '0, m1: '0, m2: MAT_ONE};
    end else begin
      row_x <= row_x_next;
      row_y <= row_y_next;
      row_z <= row_z_next;
    end
  end

endmodule

/* rtl/qrot_dot.sv */
// three-stage pipelined dot product of one matrix row, with rounding and saturation
module qrot_dot import qrot_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                       clk,
  input  qrot_adv_t                  adv,
  input  logic [COMPONENT_WIDTH-1:0] vec_x,
  input  logic [COMPONENT_WIDTH-1:0] vec_y,
  input  logic [COMPONENT_WIDTH-1:0] vec_z,
  input  mat_row_t                   row,
  output logic [COMPONENT_WIDTH-1:0] res,
  output logic                       sat
);

  localparam int LO_W = COMPONENT_WIDTH / 2;
  localparam int HI_W = COMPONENT_WIDTH - LO_W;
  localparam int PH_W = HI_W + MAT_W;
  localparam int PL_W = LO_W + 1 + MAT_W;
  localparam int HS_W = PH_W + 2;
  localparam int LS_W = PL_W + 2;
  localparam int T_W  = HS_W + LO_W + 1;
  localparam int R_W  = T_W - MAT_FRAC;
  localparam int CW   = COMPONENT_WIDTH;

  localparam logic signed [LS_W-1:0] RND_HALF = LS_W'(1) << (MAT_FRAC - 1);

  logic [CW-1:0]            v [3];
  mat_term_t                m [3];
  logic signed [PH_W-1:0]   ph [3];
  logic signed [PL_W-1:0]   pl [3];
  logic signed [HS_W-1:0]   hs;
  logic signed [LS_W-1:0]   ls;
  logic signed [T_W-1:0]    total;
  logic signed [R_W-1:0]    rnd;
  logic                     ovf;
  logic [CW-1:0]            res_next;

  assign v[0] = vec_x;
  assign v[1] = vec_y;
  assign v[2] = vec_z;
  assign m[0] = row.m0;
  assign m[1] = row.m1;
  assign m[2] = row.m2;

  // stage 2: partial products of the signed high and unsigned low halves
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int i = 0; i < 3; i++) begin
        ph[i] <= PH_W'($signed(v[i][CW-1:LO_W])) * PH_W'(m[i]);
        pl[i] <= PL_W'($signed({1'b0, v[i][LO_W-1:0]})) * PL_W'(m[i]);
      end
    end
  end

  // stage 3: column sums, rounding half added to the low sum
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      hs <= HS_W'(ph[0]) + HS_W'(ph[1]) + HS_W'(ph[2]);
      ls <= LS_W'(pl[0]) + LS_W'(pl[1]) + LS_W'(pl[2]) + RND_HALF;
    end
  end

  // stage 4: recombine, floor to 16 fraction bits, clip
  always_comb begin
    total = (T_W'(hs) <<< LO_W) + T_W'(ls);
    rnd   = total[T_W-1:MAT_FRAC];
    ovf   = !((&rnd[R_W-1:CW-1]) || !(|rnd[R_W-1:CW-1]));
    if (ovf) begin
      res_next = rnd[R_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      res_next = rnd[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      res <= res_next;
      sat <= ovf;
    end
  end

endmodule

/* rtl/vec4_quaternion_rotate_unit.sv */
// top level of the quaternion vector rotation unit
// Rotates a stream of four-component Q16.16 vectors by the quaternion held in
// registers 0 to 3 (x, y, z, w, signed Q2.14, reset to identity); w passes
// through, x, y and z are rounded to nearest and clipped, with tuser set when
// any of them was clipped. The quaternion is used as written, not normalised.
// One item is taken every cycle unless every stage is full and the output is
// held; a result passes the input register, product stage, sum stage and
// output register, and stalls move back stage by stage so empty stages still
// fill. A register write passes the quaternion and matrix registers and
// applies to every item accepted after the write.
module vec4_quaternion_rotate_unit import qrot_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // vec_x, vec_y, vec_z, vec_w from bit 0 up, zero padded to bytes
  input  logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x, out_y, out_z, out_w from bit 0 up, zero padded to bytes
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic                  m_axis_tuser
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int TDATA_W = ((4*CW+7)/8)*8;
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  mat_row_t  row_x, row_y, row_z;
  qrot_adv_t adv;

  logic          v1, v2, v3, v4;
  logic [CW-1:0] s1_x, s1_y, s1_z, s1_w;
  logic [CW-1:0] s2_w, s3_w, s4_w;
  logic [CW-1:0] res_x, res_y, res_z;
  logic          sat_x, sat_y, sat_z;

  assign cfg_ready = 1'b1;

  qrot_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_x     (row_x),
    .row_y     (row_y),
    .row_z     (row_z)
  );

  // stage advance, a stage moves when it is empty or the next one moves
  assign adv.s4        = !v4 || m_axis_tready;
  assign adv.s3        = !v3 || adv.s4;
  assign adv.s2        = !v2 || adv.s3;
  assign s_axis_tready = !v1 || adv.s2;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (s_axis_tready) v1 <= s_axis_tvalid;
      if (adv.s2)        v2 <= v1;
      if (adv.s3)        v3 <= v2;
      if (adv.s4)        v4 <= v3;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      s1_x <= s_axis_tdata[CW-1:0];
      s1_y <= s_axis_tdata[2*CW-1:CW];
      s1_z <= s_axis_tdata[3*CW-1:2*CW];
      s1_w <= s_axis_tdata[4*CW-1:3*CW];
    end
  end

  // w travels alongside the dot products
  always_ff @(posedge clk) begin
    if (adv.s2) s2_w <= s1_w;
    if (adv.s3) s3_w <= s2_w;
    if (adv.s4) s4_w <= s3_w;
  end

  qrot_dot #(.COMPONENT_WIDTH(CW)) u_dot_x (
    .clk (clk), .adv (adv), .vec_x (s1_x), .vec_y (s1_y), .vec_z (s1_z),
    .row (row_x), .res (res_x), .sat (sat_x)
  );

  qrot_dot #(.COMPONENT_WIDTH(CW)) u_dot_y (
    .clk (clk), .adv (adv), .vec_x (s1_x), .vec_y (s1_y), .vec_z (s1_z),
    .row (row_y), .res (res_y), .sat (sat_y)
  );

  qrot_dot #(.COMPONENT_WIDTH(CW)) u_dot_z (
    .clk (clk), .adv (adv), .vec_x (s1_x), .vec_y (s1_y), .vec_z (s1_z),
    .row (row_z), .res (res_z), .sat (sat_z)
  );

  // result item
  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = TDATA_W'({s4_w, res_z, res_y, res_x});
  assign m_axis_tuser  = sat_x || sat_y || sat_z;

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // the input only stalls when every stage is full and the output is held
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v1 && v2 && v3 && v4 && !m_axis_tready))
    else $error("input stalled with a free stage");

  // a clipped result leaves at least one component on a bound
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (res_x == SAT_MAX || res_x == SAT_MIN || res_y == SAT_MAX ||
       res_y == SAT_MIN || res_z == SAT_MAX || res_z == SAT_MIN))
    else $error("saturation flag without a clipped component");

endmodule
